/* rtl/tws_pkg.sv */
// Shared types and constants for the timer wheel scheduler.
// No dependencies; every rtl module imports this package.
`default_nettype none
package tws_pkg;

  localparam int unsigned NumTimersDefault = 32;

  typedef enum logic [1:0] {
    OP_ARM    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [4:0]         timer_id;
    logic [31:0]        expires;
    logic signed [31:0] interval;
    logic               periodic;
  } cmd_t;

  typedef struct packed {
    logic [4:0] fired_id;
    logic       last;
  } res_t;

  typedef struct packed {
    logic        active;
    logic [31:0] due;
    logic [31:0] interval;
    logic        periodic;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // A due time in the signed past is moved up to the reference time.
  function automatic logic [31:0] clamp_due(input logic [31:0] due, input logic [31:0] now);
    logic [31:0] diff;
    diff = due - now;
    return diff[31] ? now : due;
  endfunction

endpackage
`default_nettype wire

/* rtl/tws_cell.sv */
// One timer entry in the rotating ring of cells.
// Depends on tws_pkg.
`default_nettype none
module tws_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            shift,
  input  wire tws_pkg::entry_t d,
  output tws_pkg::entry_t      q
);
  import tws_pkg::*;

  entry_t entry;

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= d;
    end
    if (rst) begin
      entry.active <= 1'b0;
    end
  end

  assign q = entry;

endmodule
`default_nettype wire

/* rtl/tws_head.sv */
// Update logic at the head of the ring: applies the current item to the entry passing by.
// Depends on tws_pkg.
`default_nettype none
module tws_head #(
  parameter int unsigned CntW = 5
) (
  input  wire tws_pkg::cmd_t   cmd,
  input  wire logic [CntW-1:0] idx,
  input  wire logic [31:0]     now,
  input  wire tws_pkg::entry_t cur,
  output tws_pkg::entry_t      upd,
  output logic                 fire
);
  import tws_pkg::*;

  logic        hit;
  logic [31:0] now_next;

  assign hit      = (32'(cmd.timer_id) == 32'(idx));
  assign now_next = now + 32'd1;

  always_comb begin
    upd  = cur;
    fire = 1'b0;
    unique case (op_t'(cmd.op))
      OP_ARM: begin
        if (hit) begin
          upd.active   = 1'b1;
          upd.due      = clamp_due(cmd.expires, now);
          upd.interval = cmd.interval;
          upd.periodic = cmd.periodic;
        end
      end
      OP_CANCEL: begin
        if (hit) begin
          upd.active = 1'b0;
        end
      end
      OP_TICK: begin
        if (cur.active && cur.due == now) begin
          fire = 1'b1;
          if (cur.periodic) begin
            upd.due = clamp_due(cur.due + cur.interval, now_next);
          end else begin
            upd.active = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/timer_wheel_scheduler.sv */
// Timer scheduler: every item rotates the whole ring of timer cells once past one update head.
// An item is accepted in idle, then the ring shifts one cell per step while scanning, and a final
// flush emits the last pending fire; stalls on res hold the scan and the flush.
// The single head of the ring takes no new item until the current one is back in idle.
// Synchronous reset frees all timers and loads current time with zero; entry payload is not reset.
`default_nettype none
module timer_wheel_scheduler #(
  parameter int unsigned NUM_TIMERS = tws_pkg::NumTimersDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire tws_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output tws_pkg::res_t      res,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [31:0]   cfg_data
);
  import tws_pkg::*;

  localparam int unsigned CntW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(NUM_TIMERS - 1);

  state_t state, state_next;
  cmd_t   op_reg;
  logic [31:0] now;
  logic [CntW-1:0] idx;
  logic        pend_v;
  logic [4:0]  pend_id;
  logic        out_free, advance, fire;
  entry_t      ring [NUM_TIMERS];
  entry_t      upd;

  assign out_free  = !res_valid || res_ready;
  assign cmd_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    entry_t d;
    if (i == NUM_TIMERS - 1) begin : g_tail
      assign d = upd;
    end else begin : g_mid
      assign d = ring[i+1];
    end
    tws_cell u_cell (.clk(clk), .rst(rst), .shift(advance), .d(d), .q(ring[i]));
  end

  tws_head #(.CntW(CntW)) u_head (
    .cmd(op_reg), .idx(idx), .now(now), .cur(ring[0]), .upd(upd), .fire(fire)
  );

  // A fire with a pending one waiting needs the output register.
  always_comb begin
    state_next = state;
    advance    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        advance = !(fire && pend_v && !out_free);
        if (advance && idx == LastIdx) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now       <= 32'd0;
      idx       <= '0;
      pend_v    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_valid) begin
        now <= cfg_data;
      end
      if (state == ST_IDLE && cmd_valid) begin
        op_reg <= cmd;
        idx    <= '0;
      end
      if (advance) begin
        idx <= idx + CntW'(1);
        if (fire) begin
          pend_v  <= 1'b1;
          pend_id <= 5'(idx);
          if (pend_v) begin
            res_valid    <= 1'b1;
            res.fired_id <= pend_id;
            res.last     <= 1'b0;
          end
        end
      end
      if (state == ST_FLUSH && state_next == ST_IDLE) begin
        if (op_t'(op_reg.op) == OP_TICK) begin
          now <= now + 32'd1;
        end
        if (pend_v) begin
          pend_v       <= 1'b0;
          res_valid    <= 1'b1;
          res.fired_id <= pend_id;
          res.last     <= 1'b1;
        end
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result overwritten while stalled");
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && advance && idx == LastIdx |=> state == ST_FLUSH)
    else $error("scan did not end after last cell");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_v)
    else $error("pending fire left over in idle");
  a_fire_only_tick: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN && fire |-> op_t'(op_reg.op) == OP_TICK)
    else $error("fire outside a tick");

endmodule
`default_nettype wire

/* sim/timer_wheel_scheduler_test.sv */
// Self-checking testbench for timer_wheel_scheduler: arm, cancel and tick items with a
// local timer-table predictor, randomized gaps on both channels. Depends on all rtl files.
`default_nettype none
module timer_wheel_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tws_pkg::*;

  localparam int NTIM = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic cfg_valid;
  logic cfg_ready;
  logic [31:0] cfg_data;

  timer_wheel_scheduler DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predicted timer table.
  logic [31:0] now_time;
  logic        tm_active [NTIM];
  logic [31:0] tm_due [NTIM];
  logic [31:0] tm_interval [NTIM];
  logic        tm_periodic [NTIM];

  cmd_t pending_cmds[$];
  res_t fired_queue[$];
  int   mismatches;
  int   idle_cycles;
  bit   hold_off;

  function automatic logic [31:0] pull_due(input logic [31:0] due);
    logic [31:0] diff;
    diff = due - now_time;
    return diff[31] ? now_time : due;
  endfunction

  task automatic predict_fires(input cmd_t c);
    logic [31:0] old;
    int first_of_tick;
    res_t r;
    first_of_tick = fired_queue.size();
    case (c.op)
      OP_ARM: begin
        tm_due[c.timer_id] = pull_due(c.expires);
        tm_interval[c.timer_id] = c.interval;
        tm_periodic[c.timer_id] = c.periodic;
        tm_active[c.timer_id] = 1'b1;
      end
      OP_CANCEL: tm_active[c.timer_id] = 1'b0;
      OP_TICK: begin
        old = now_time;
        now_time = old + 1;
        for (int i = 0; i < NTIM; i++) begin
          if (tm_active[i] && tm_due[i] == old) begin
            r.fired_id = i[4:0];
            r.last = 1'b0;
            fired_queue.push_back(r);
            if (tm_periodic[i]) tm_due[i] = pull_due(tm_due[i] + tm_interval[i]);
            else tm_active[i] = 1'b0;
          end
        end
        if (fired_queue.size() > first_of_tick) fired_queue[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver.
  int send_gap;
  bit no_idle;
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (cmd_valid && cmd_ready) predict_fires(cmd);
      if (!cmd_valid || cmd_ready) begin
        if (send_gap > 0) begin
          cmd_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0 && !hold_off) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
          send_gap <= no_idle ? 0 : gap_len();
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  int recv_gap;
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (fired_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: fired_id=%0d last=%0b", res.fired_id, res.last);
        end else begin
          want = fired_queue.pop_front();
          if (want.fired_id !== res.fired_id || want.last !== res.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected id=%0d last=%0b, got id=%0d last=%0b",
                       want.fired_id, want.last, res.fired_id, res.last);
          end
        end
      end
      if (recv_gap > 0) begin
        res_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        res_ready <= 1'b1;
        recv_gap <= (no_idle || $urandom_range(0, 1)) ? 0 : gap_len();
      end
    end
  end

  // Watchdog on cycles with no accepted item.
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(input logic [1:0] op, input logic [4:0] id,
                                    input logic [31:0] exp, input logic [31:0] iv,
                                    input logic per);
    cmd_t c;
    c.op = op;
    c.timer_id = id;
    c.expires = exp;
    c.interval = iv;
    c.periodic = per;
    return c;
  endfunction

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || cmd_valid || fired_queue.size() > 0) @(posedge clk);
    repeat (3 * NTIM + 10) @(posedge clk);
  endtask

  task automatic write_start(input logic [31:0] value);
    @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    now_time = value;
  endtask

  // Random mix: mostly arms near the current time and ticks, some cancels and noise.
  task automatic queue_random(input int count);
    int k;
    logic [31:0] base;
    base = now_time;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      if (k < 35)
        pending_cmds.push_back(make_cmd(OP_ARM, 5'($urandom()),
          ($urandom_range(0, 9) == 0) ? $urandom() : base + n / 2 + $urandom_range(0, 12) - 3,
          ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 6) - 1,
          1'($urandom())));
      else if (k < 45)
        pending_cmds.push_back(make_cmd(OP_CANCEL, 5'($urandom()), $urandom(), $urandom(),
                                        1'($urandom())));
      else if (k < 48)
        pending_cmds.push_back(make_cmd(OP_NONE, 5'($urandom()), $urandom(), $urandom(),
                                        1'($urandom())));
      else
        pending_cmds.push_back(make_cmd(OP_TICK, 5'($urandom()), $urandom(), $urandom(),
                                        1'($urandom())));
    end
  endtask

  initial begin
    logic [31:0] t;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    res_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    hold_off = 1'b0;
    no_idle = 1'b0;
    now_time = 32'd0;
    for (int i = 0; i < NTIM; i++) begin
      tm_active[i] = 1'b0;
      tm_due[i] = '0;
      tm_interval[i] = '0;
      tm_periodic[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    // Directed: start near the wrap point so the due times cross it.
    write_start(32'hFFFF_FFFE);
    t = now_time;
    pending_cmds.push_back(make_cmd(OP_ARM, 5'd0, t, 32'd0, 1'b1));
    pending_cmds.push_back(make_cmd(OP_ARM, 5'd31, t + 1, 32'h7FFF_FFFF, 1'b1));
    pending_cmds.push_back(make_cmd(OP_ARM, 5'd7, t - 100, 32'h8000_0000, 1'b0));
    pending_cmds.push_back(make_cmd(OP_ARM, 5'd9, t + 2, 32'hFFFF_FFFF, 1'b1));
    pending_cmds.push_back(make_cmd(OP_ARM, 5'd9, t + 3, 32'd2, 1'b1));
    pending_cmds.push_back(make_cmd(OP_CANCEL, 5'd12, '0, '0, 1'b0));
    pending_cmds.push_back(make_cmd(OP_NONE, 5'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    for (int i = 0; i < 5; i++) pending_cmds.push_back(make_cmd(OP_TICK, '0, '0, '0, 1'b0));
    pending_cmds.push_back(make_cmd(OP_CANCEL, 5'd0, '0, '0, 1'b0));
    pending_cmds.push_back(make_cmd(OP_ARM, 5'd3, t + 32'h8000_0000, 32'd1, 1'b0));
    pending_cmds.push_back(make_cmd(OP_TICK, '0, '0, '0, 1'b0));
    pending_cmds.push_back(make_cmd(OP_TICK, '0, '0, '0, 1'b0));

    // Sender holds off until every fire is taken, then runs with no idling on either side.
    wait_drained();
    hold_off = 1'b1;
    for (int i = 0; i < NTIM; i++)
      pending_cmds.push_back(make_cmd(OP_ARM, i[4:0], now_time, 32'd1, 1'b1));
    for (int i = 0; i < 3; i++) pending_cmds.push_back(make_cmd(OP_TICK, '0, '0, '0, 1'b0));
    for (int i = 0; i < NTIM; i++)
      pending_cmds.push_back(make_cmd(OP_CANCEL, i[4:0], '0, '0, 1'b0));
    no_idle = 1'b1;
    hold_off = 1'b0;
    wait_drained();
    no_idle = 1'b0;

    write_start(32'd0);
    queue_random(80);
    wait_drained();
    write_start(32'hFFFF_FFFF);
    queue_random(80);
    wait_drained();
    write_start($urandom());
    queue_random(80);
    wait_drained();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
